FILE: rtl/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg
// Shared types, operation codes and defaults for the slotted job queue.
// ----------------------------------------------------------------------------
package sjq_pkg;

  localparam int DEPTH_DEFAULT = 12;
  localparam int SLOTS_DEFAULT = 2;

  localparam logic [2:0] FUNC_ENQUEUE   = 3'd0;
  localparam logic [2:0] FUNC_DEQUEUE   = 3'd1;
  localparam logic [2:0] FUNC_CLR_IDLE  = 3'd2;
  localparam logic [2:0] FUNC_CLR_ALL   = 3'd3;
  localparam logic [2:0] FUNC_MARK_WORK = 3'd4;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  localparam logic [1:0] ENTRY_INVALID = 2'd0;
  localparam logic [1:0] ENTRY_IDLE    = 2'd1;
  localparam logic [1:0] ENTRY_WORKING = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] job_tag;
    logic [31:0] job_handle;
    logic [2:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        evicted;
    logic [15:0] evicted_tag;
    logic [3:0]  occupancy;
  } res_t;

endpackage

FILE: rtl/sjq_compact.sv
// ----------------------------------------------------------------------------
// sjq_compact
// Select network that packs the working entries to the front of the queue.
// Row w of the select matrix is one-hot on the entry that lands at position w, or all zero if none does.
// ----------------------------------------------------------------------------
module sjq_compact #(
  parameter int DEPTH = sjq_pkg::DEPTH_DEFAULT
) (
  input  logic [1:0]       entry_state [DEPTH],
  output logic [DEPTH-1:0] sel         [DEPTH],
  output logic [$clog2(DEPTH+1)-1:0] work_count
);

  localparam int CntW = $clog2(DEPTH+1);

  logic [DEPTH-1:0] work;
  logic [CntW-1:0]  rank [DEPTH];
  logic [CntW-1:0]  total;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      work[i] = (entry_state[i] == sjq_pkg::ENTRY_WORKING);
    end
    for (int i = 0; i < DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < i; j++) begin
        rank[i] = rank[i] + CntW'(work[j]);
      end
    end
    total = '0;
    for (int j = 0; j < DEPTH; j++) begin
      total = total + CntW'(work[j]);
    end
    for (int w = 0; w < DEPTH; w++) begin
      for (int i = 0; i < DEPTH; i++) begin
        sel[w][i] = work[i] && (rank[i] == CntW'(w));
      end
    end
  end

  assign work_count = total;

endmodule

FILE: rtl/sjq_core.sv
// ----------------------------------------------------------------------------
// sjq_core
// Queue entries and the single-pass update logic for one operation per cycle while fire is high.
// The result for the presented command is produced combinationally.
// ----------------------------------------------------------------------------
module sjq_core #(
  parameter int DEPTH = sjq_pkg::DEPTH_DEFAULT,
  parameter int SLOTS = sjq_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  sjq_pkg::cmd_t  cmd,
  output sjq_pkg::res_t  res
);

  localparam int CntW   = $clog2(DEPTH+1);
  localparam int IdxW   = $clog2(DEPTH);
  localparam int EvLim  = (SLOTS < DEPTH-1) ? SLOTS : DEPTH-1;
  localparam int DqLim  = (SLOTS < DEPTH) ? SLOTS : DEPTH;

  logic [1:0]  entry_state  [DEPTH];
  logic [15:0] entry_tag    [DEPTH];
  logic [31:0] entry_handle [DEPTH];
  logic [CntW-1:0] cnt;

  logic [1:0]  entry_state_next  [DEPTH];
  logic [15:0] entry_tag_next    [DEPTH];
  logic [31:0] entry_handle_next [DEPTH];
  logic [CntW-1:0] cnt_next;

  logic [DEPTH-1:0] sel [DEPTH];
  logic [CntW-1:0]  work_count;

  logic            full;
  logic            ev_found;
  logic [IdxW-1:0] ev_pos;
  logic [15:0]     ev_tag;
  logic            dq_found;
  logic [IdxW-1:0] dq_pos;
  logic            slot_ok;

  logic            rm_en;
  logic [IdxW-1:0] rm_pos;
  logic            wr_en;
  logic [IdxW-1:0] wr_pos;
  logic            mark_en;
  logic            clr_all;
  logic            clr_idle;
  logic [1:0]      status;
  logic            evicted;
  logic [CntW+3:0] occ_ext;

  sjq_compact #(
    .DEPTH (DEPTH)
  ) u_compact (
    .entry_state (entry_state),
    .sel         (sel),
    .work_count  (work_count)
  );

  always_comb begin
    full = (cnt == CntW'(DEPTH));

    ev_found = 1'b0;
    ev_pos   = '0;
    ev_tag   = '0;
    for (int i = 0; i <= EvLim; i++) begin
      if (!ev_found && entry_state[i] == sjq_pkg::ENTRY_IDLE) begin
        ev_found = 1'b1;
        ev_pos   = IdxW'(i);
        ev_tag   = entry_tag[i];
      end
    end

    dq_found = 1'b0;
    dq_pos   = '0;
    for (int i = 0; i < DqLim; i++) begin
      if (!dq_found && entry_state[i] != sjq_pkg::ENTRY_INVALID
          && entry_tag[i] == cmd.job_tag) begin
        dq_found = 1'b1;
        dq_pos   = IdxW'(i);
      end
    end

    slot_ok = 1'b0;
    for (int i = 0; i < DqLim; i++) begin
      if ({1'b0, cmd.slot_index} == 4'(i) && entry_state[i] != sjq_pkg::ENTRY_INVALID) begin
        slot_ok = 1'b1;
      end
    end

    rm_en    = 1'b0;
    rm_pos   = '0;
    wr_en    = 1'b0;
    wr_pos   = '0;
    mark_en  = 1'b0;
    clr_all  = 1'b0;
    clr_idle = 1'b0;
    status   = sjq_pkg::STATUS_DONE;
    evicted  = 1'b0;
    cnt_next = cnt;

    unique case (cmd.func)
      sjq_pkg::FUNC_ENQUEUE: begin
        if (!full) begin
          wr_en    = 1'b1;
          wr_pos   = cnt[IdxW-1:0];
          cnt_next = cnt + CntW'(1);
        end else if (ev_found) begin
          rm_en   = 1'b1;
          rm_pos  = ev_pos;
          wr_en   = 1'b1;
          wr_pos  = IdxW'(DEPTH-1);
          evicted = 1'b1;
        end else begin
          status = sjq_pkg::STATUS_EMPTY;
        end
      end
      sjq_pkg::FUNC_DEQUEUE: begin
        if (dq_found) begin
          rm_en    = 1'b1;
          rm_pos   = dq_pos;
          cnt_next = cnt - CntW'(1);
        end else begin
          status = sjq_pkg::STATUS_NO_MATCH;
        end
      end
      sjq_pkg::FUNC_CLR_IDLE: begin
        clr_idle = 1'b1;
        cnt_next = work_count;
      end
      sjq_pkg::FUNC_CLR_ALL: begin
        clr_all  = 1'b1;
        cnt_next = '0;
      end
      sjq_pkg::FUNC_MARK_WORK: begin
        if (slot_ok) begin
          mark_en = 1'b1;
        end else begin
          status = sjq_pkg::STATUS_EMPTY;
        end
      end
      default: begin
        status = sjq_pkg::STATUS_DONE;
      end
    endcase

    for (int i = 0; i < DEPTH; i++) begin
      entry_state_next[i]  = entry_state[i];
      entry_tag_next[i]    = entry_tag[i];
      entry_handle_next[i] = entry_handle[i];
      if (rm_en && IdxW'(i) >= rm_pos) begin
        if (i < DEPTH-1) begin
          entry_state_next[i]  = entry_state[(i+1) % DEPTH];
          entry_tag_next[i]    = entry_tag[(i+1) % DEPTH];
          entry_handle_next[i] = entry_handle[(i+1) % DEPTH];
        end else begin
          entry_state_next[i] = sjq_pkg::ENTRY_INVALID;
        end
      end
      if (wr_en && IdxW'(i) == wr_pos) begin
        entry_state_next[i]  = sjq_pkg::ENTRY_IDLE;
        entry_tag_next[i]    = cmd.job_tag;
        entry_handle_next[i] = cmd.job_handle;
      end
      if (mark_en && int'(cmd.slot_index) == i) begin
        entry_state_next[i] = sjq_pkg::ENTRY_WORKING;
      end
      if (clr_all) begin
        entry_state_next[i] = sjq_pkg::ENTRY_INVALID;
      end
      if (clr_idle) begin
        entry_state_next[i]  = (|sel[i]) ? sjq_pkg::ENTRY_WORKING : sjq_pkg::ENTRY_INVALID;
        entry_tag_next[i]    = '0;
        entry_handle_next[i] = '0;
        for (int j = 0; j < DEPTH; j++) begin
          entry_tag_next[i]    = entry_tag_next[i] | (entry_tag[j] & {16{sel[i][j]}});
          entry_handle_next[i] = entry_handle_next[i] | (entry_handle[j] & {32{sel[i][j]}});
        end
      end
    end

    occ_ext       = {4'b0, cnt_next};
    res.status      = status;
    res.evicted     = evicted;
    res.evicted_tag = evicted ? ev_tag : 16'h0;
    res.occupancy   = occ_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        entry_state[i] <= sjq_pkg::ENTRY_INVALID;
      end
    end else if (fire) begin
      cnt <= cnt_next;
      for (int i = 0; i < DEPTH; i++) begin
        entry_state[i] <= entry_state_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_tag[i]    <= entry_tag_next[i];
        entry_handle[i] <= entry_handle_next[i];
      end
    end
  end

endmodule

FILE: rtl/slotted_job_queue_with_eviction_top.sv
// ----------------------------------------------------------------------------
// slotted_job_queue_with_eviction_top
// Job queue with service slots, eviction of idle jobs on a full queue,
// dequeue by tag, clear and mark operations.
//
// Each command enters on the slave stream (s_tvalid, s_tready, s_tdata) and
// produces exactly one result transfer on the master stream (m_tvalid,
// m_tready, m_tdata), in command order.
// A command is captured in an input register; when the output register is free or
// being read, the queue is updated and the result is loaded into the output
// register. A new command is taken every cycle while the receiver does not stall,
// since each operation is one pass through the per-entry shift and compaction
// selects.
// While the receiver stalls, the output register holds its result and one
// further command waits in the input register; then s_tready drops.
// Reset empties the queue, marks all entries invalid and drops any pending
// command or result. Tags and handles are never read from empty entries.
// ----------------------------------------------------------------------------
module slotted_job_queue_with_eviction_top #(
  parameter int DEPTH = sjq_pkg::DEPTH_DEFAULT,
  parameter int SLOTS = sjq_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // func[2:0], job_tag[18:3], job_handle[50:19], slot_index[53:51], zero fill
  input  logic [sjq_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[1:0], evicted[2], evicted_tag[18:3], occupancy[22:19], zero fill
  output logic [sjq_pkg::OUT_DATA_W-1:0] m_tdata
);

  sjq_pkg::cmd_t cmd;
  logic          cmd_valid;
  sjq_pkg::res_t res;
  sjq_pkg::res_t res_comb;
  logic          advance;
  logic          s_fire;

  assign advance  = cmd_valid && (!m_tvalid || m_tready);
  assign s_tready = !cmd_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (s_fire) begin
        cmd_valid <= 1'b1;
      end else if (advance) begin
        cmd_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      cmd.func       <= s_tdata[2:0];
      cmd.job_tag    <= s_tdata[18:3];
      cmd.job_handle <= s_tdata[50:19];
      cmd.slot_index <= s_tdata[53:51];
    end
    if (advance) begin
      res <= res_comb;
    end
  end

  sjq_core #(
    .DEPTH (DEPTH),
    .SLOTS (SLOTS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cmd  (cmd),
    .res  (res_comb)
  );

  assign m_tdata = {1'b0, res.occupancy, res.evicted_tag, res.evicted, res.status};

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the slotted job queue against its own behavioral copy of the queue.
// A directed sequence covers:
//   - empty and out-of-range marks, and marking a slot that is already working
//   - matched and unmatched dequeues
//   - filling the queue and evicting idle jobs from a full queue
//   - clear idle, clear all and an unused operation code
// Random commands follow, in fill-heavy and drain-heavy phases, with bursty
// input traffic and a stalling receiver. Every result is compared with the
// predicted one.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = sjq_pkg::DEPTH_DEFAULT;
  localparam int SLOTS        = sjq_pkg::SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  class job_queue_model;
    logic [1:0]    entry_state  [DEPTH];
    logic [15:0]   entry_tag    [DEPTH];
    logic [31:0]   entry_handle [DEPTH];
    sjq_pkg::res_t pending_results [$];
    int            failures;

    function new();
      failures = 0;
      clear_all();
    endfunction

    function void clear_all();
      for (int i = 0; i < DEPTH; i++) begin
        entry_state[i]  = sjq_pkg::ENTRY_INVALID;
        entry_tag[i]    = '0;
        entry_handle[i] = '0;
      end
    endfunction

    function int count_valid();
      int n;
      n = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (entry_state[i] != sjq_pkg::ENTRY_INVALID) n++;
      end
      return n;
    endfunction

    function void drop_entry(int pos);
      for (int i = pos; i < DEPTH - 1; i++) begin
        entry_state[i]  = entry_state[i + 1];
        entry_tag[i]    = entry_tag[i + 1];
        entry_handle[i] = entry_handle[i + 1];
      end
      entry_state[DEPTH - 1]  = sjq_pkg::ENTRY_INVALID;
      entry_tag[DEPTH - 1]    = '0;
      entry_handle[DEPTH - 1] = '0;
    endfunction

    function void note_command(logic [2:0] func, logic [15:0] tag, logic [31:0] handle,
                               logic [2:0] slot);
      sjq_pkg::res_t r;
      int            n;
      int            lim;
      int            pos;
      int            w;
      r   = '0;
      pos = -1;
      w   = 0;
      case (func)
        sjq_pkg::FUNC_ENQUEUE: begin
          n = count_valid();
          if (n < DEPTH) begin
            entry_state[n]  = sjq_pkg::ENTRY_IDLE;
            entry_tag[n]    = tag;
            entry_handle[n] = handle;
          end else begin
            lim = (SLOTS < DEPTH - 1) ? SLOTS : DEPTH - 1;
            for (int i = 0; i <= lim; i++) begin
              if (pos < 0 && entry_state[i] == sjq_pkg::ENTRY_IDLE) pos = i;
            end
            if (pos >= 0) begin
              r.evicted     = 1'b1;
              r.evicted_tag = entry_tag[pos];
              drop_entry(pos);
              entry_state[DEPTH - 1]  = sjq_pkg::ENTRY_IDLE;
              entry_tag[DEPTH - 1]    = tag;
              entry_handle[DEPTH - 1] = handle;
            end else begin
              r.status = sjq_pkg::STATUS_EMPTY;
            end
          end
        end
        sjq_pkg::FUNC_DEQUEUE: begin
          lim = (SLOTS < DEPTH) ? SLOTS : DEPTH;
          r.status = sjq_pkg::STATUS_NO_MATCH;
          for (int i = 0; i < lim; i++) begin
            if (r.status == sjq_pkg::STATUS_NO_MATCH &&
                entry_state[i] != sjq_pkg::ENTRY_INVALID && entry_tag[i] == tag) begin
              drop_entry(i);
              r.status = sjq_pkg::STATUS_DONE;
            end
          end
        end
        sjq_pkg::FUNC_CLR_IDLE: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (entry_state[i] == sjq_pkg::ENTRY_WORKING) begin
              entry_state[w]  = entry_state[i];
              entry_tag[w]    = entry_tag[i];
              entry_handle[w] = entry_handle[i];
              w++;
            end
          end
          for (int i = w; i < DEPTH; i++) begin
            entry_state[i]  = sjq_pkg::ENTRY_INVALID;
            entry_tag[i]    = '0;
            entry_handle[i] = '0;
          end
        end
        sjq_pkg::FUNC_CLR_ALL: begin
          clear_all();
        end
        sjq_pkg::FUNC_MARK_WORK: begin
          if (slot < SLOTS && slot < DEPTH &&
              entry_state[slot] != sjq_pkg::ENTRY_INVALID) begin
            entry_state[slot] = sjq_pkg::ENTRY_WORKING;
          end else begin
            r.status = sjq_pkg::STATUS_EMPTY;
          end
        end
        default: begin
        end
      endcase
      r.occupancy = 4'(count_valid());
      pending_results.push_back(r);
    endfunction

    function void report_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [sjq_pkg::OUT_DATA_W-1:0] data);
      sjq_pkg::res_t got;
      sjq_pkg::res_t want;
      got.status      = data[1:0];
      got.evicted     = data[2];
      got.evicted_tag = data[18:3];
      got.occupancy   = data[22:19];
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result status %0d evicted %0d tag %h occupancy %0d",
                                 got.status, got.evicted, got.evicted_tag, got.occupancy));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report_failure($sformatf(
            "expected status %0d evicted %0d tag %h occupancy %0d, got %0d %0d %h %0d",
            want.status, want.evicted, want.evicted_tag, want.occupancy,
            got.status, got.evicted, got.evicted_tag, got.occupancy));
        end
      end
    endfunction
  endclass

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sjq_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sjq_pkg::OUT_DATA_W-1:0] m_tdata;

  job_queue_model queue_model;
  int             cycle_count = 0;
  int             stall_left  = 0;
  int             stall_mode  = 0;

  slotted_job_queue_with_eviction_top #(
    .DEPTH(DEPTH),
    .SLOTS(SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) queue_model.check_result(m_tdata);
  end

  // The receiver alternates between always ready, random ready and hard stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      2: m_tready = 1'($urandom_range(0, 1));
      3: m_tready = 1'b0;
      default: m_tready = 1'b1;
    endcase
  end

  task automatic send_command(input logic [2:0] func, input logic [15:0] tag,
                              input logic [31:0] handle, input logic [2:0] slot);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, slot, handle, tag, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    queue_model.note_command(func, tag, handle, slot);
  endtask

  initial begin
    logic [2:0]  func;
    logic [15:0] tag;
    logic [15:0] tag_base;
    logic [2:0]  slot;
    int          pick;
    int          enq_cut;
    int          deq_cut;
    int          mark_cut;
    int          clr_idle_cut;
    int          clr_all_cut;
    int          burst_left;
    int          gap;
    bit          fill_phase;

    queue_model = new();
    tag_base    = 16'($urandom);
    burst_left  = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_command(sjq_pkg::FUNC_DEQUEUE, 16'h0000, 32'h0000_0000, 3'd0);
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'h0000, 32'h0000_0000, 3'd0);
    send_command(sjq_pkg::FUNC_ENQUEUE, 16'h0000, 32'h0000_0000, 3'd7);
    send_command(sjq_pkg::FUNC_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 3'd0);
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'hFFFF, 32'hFFFF_FFFF, 3'd0);
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'h0000, 32'h0000_0000, 3'd0);
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'h0000, 32'h0000_0000, 3'(SLOTS));
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'h0000, 32'h0000_0000, 3'd7);
    send_command(sjq_pkg::FUNC_DEQUEUE, 16'h1234, 32'h0000_0000, 3'd0);
    send_command(sjq_pkg::FUNC_DEQUEUE, 16'hFFFF, 32'h0000_0000, 3'd0);
    for (int k = 0; k < DEPTH - 1; k++) begin
      send_command(sjq_pkg::FUNC_ENQUEUE, 16'h0100 + 16'(k), $urandom, 3'd0);
    end
    send_command(sjq_pkg::FUNC_MARK_WORK, 16'h0000, 32'h0000_0000, 3'd1);
    send_command(sjq_pkg::FUNC_ENQUEUE, 16'hABCD, 32'h5A5A_A5A5, 3'd0);
    send_command(sjq_pkg::FUNC_ENQUEUE, 16'h4321, 32'hA5A5_5A5A, 3'd0);
    send_command(sjq_pkg::FUNC_DEQUEUE, 16'h0000, 32'h0000_0000, 3'd0);
    send_command(sjq_pkg::FUNC_CLR_IDLE, 16'h0000, 32'h0000_0000, 3'd0);
    send_command(FUNC_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
    send_command(sjq_pkg::FUNC_CLR_ALL, 16'h0000, 32'h0000_0000, 3'd0);

    // Phases alternate between filling the queue up to eviction and draining it.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fill_phase   = ((n / 150) % 2) == 0;
      enq_cut      = fill_phase ? 60 : 30;
      deq_cut      = enq_cut + (fill_phase ? 15 : 35);
      mark_cut     = deq_cut + 15;
      clr_idle_cut = mark_cut + (fill_phase ? 4 : 8);
      clr_all_cut  = clr_idle_cut + (fill_phase ? 2 : 5);
      pick         = $urandom_range(0, 99);
      if (pick < enq_cut) func = sjq_pkg::FUNC_ENQUEUE;
      else if (pick < deq_cut) func = sjq_pkg::FUNC_DEQUEUE;
      else if (pick < mark_cut) func = sjq_pkg::FUNC_MARK_WORK;
      else if (pick < clr_idle_cut) func = sjq_pkg::FUNC_CLR_IDLE;
      else if (pick < clr_all_cut) func = sjq_pkg::FUNC_CLR_ALL;
      else func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));

      tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : tag_base ^ 16'($urandom_range(0, 7));
      if (func == sjq_pkg::FUNC_DEQUEUE && $urandom_range(0, 99) < 60) begin
        tag = queue_model.entry_tag[$urandom_range(0, SLOTS - 1)];
      end
      slot = ($urandom_range(0, 99) < 75) ? 3'($urandom_range(0, SLOTS - 1))
                                          : 3'($urandom_range(0, 7));
      send_command(func, tag, $urandom, slot);

      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
        gap        = $urandom_range(0, 5);
        repeat (gap) begin
          @(negedge clk);
          s_tvalid = 1'b0;
        end
      end else begin
        burst_left = burst_left - 1;
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (queue_model.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (queue_model.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sjq_pkg.sv
rtl/sjq_compact.sv
rtl/sjq_core.sv
rtl/slotted_job_queue_with_eviction_top.sv
dv/testbench.sv
